FILE: hdl/double_to_q31_multiplier_shift_defines.svh
// assertion macros for the double to q31 converter
`ifndef DOUBLE_TO_Q31_MULTIPLIER_SHIFT_DEFINES_SVH
`define DOUBLE_TO_Q31_MULTIPLIER_SHIFT_DEFINES_SVH

// a property that must hold on every clock edge outside reset
`define D2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// an implication checked on every clock edge, reset included
`define D2Q_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/d2q_pkg.sv
// ----------------------------------------------------------------------------
// d2q_pkg
// shared types and constants for the double to q31 converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package d2q_pkg;
  localparam int FracBits = 52;
  localparam int ExpBits  = 11;
  localparam int MultBits = 32;
  localparam int ShiftBits = 12;
  localparam int LzBits = 6;

  localparam logic [ExpBits-1:0] ExpAllOnes = 11'h7ff;
  localparam logic [ShiftBits-1:0] ExpOffset = 12'd1022;
  localparam logic [ShiftBits-1:0] SubnormBase = 12'd1073;

  localparam logic [MultBits-1:0] MultPosMax = 32'h7fff_ffff;
  localparam logic [MultBits-1:0] MultNegMax = 32'h8000_0000;

  // classification after decode
  localparam logic [1:0] ClsZero = 2'd0;
  localparam logic [1:0] ClsInf  = 2'd1;
  localparam logic [1:0] ClsNorm = 2'd2;

  typedef struct packed {
    logic [1:0]           cls;
    logic                 neg;
    logic                 subnorm;
    logic [FracBits-1:0]  frac;
    logic [ExpBits-1:0]   exp_field;
    logic [LzBits-1:0]    top;
  } dec_t;

  typedef struct packed {
    logic [1:0]           cls;
    logic                 neg;
    logic [FracBits:0]    mant;
    logic [ShiftBits-1:0] shift;
  } norm_t;

  typedef struct packed {
    logic [MultBits-1:0]  mult;
    logic [ShiftBits-1:0] shift;
  } res_t;
endpackage

FILE: hdl/d2q_decode.sv
// ----------------------------------------------------------------------------
// d2q_decode
// splits the double into fields, classifies it and finds the top fraction bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module d2q_decode (
  input  logic [63:0]   value_bits,
  output d2q_pkg::dec_t dec
);
  import d2q_pkg::*;

  always_comb begin
    dec.neg = value_bits[63];
    dec.exp_field = value_bits[62:52];
    dec.frac = value_bits[51:0];
    dec.subnorm = (value_bits[62:52] == '0);
    dec.top = '0;
    for (int i = 0; i < FracBits; i++) begin
      if (value_bits[i]) dec.top = LzBits'(i);
    end
    if (value_bits[62:0] == '0) begin
      dec.cls = ClsZero;
    end else if (value_bits[62:52] == ExpAllOnes) begin
      dec.cls = (value_bits[51:0] == '0) ? ClsInf : ClsZero;
    end else begin
      dec.cls = ClsNorm;
    end
  end
endmodule

FILE: hdl/d2q_normalize.sv
// ----------------------------------------------------------------------------
// d2q_normalize
// shift of subnormals by the leading-zero count, exponent rebias
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module d2q_normalize (
  input  d2q_pkg::dec_t  dec,
  output d2q_pkg::norm_t norm
);
  import d2q_pkg::*;

  always_comb begin
    norm.cls = dec.cls;
    norm.neg = dec.neg;
    if (dec.subnorm) begin
      norm.mant = {1'b0, dec.frac} << (LzBits'(FracBits) - dec.top);
      norm.shift = ShiftBits'(dec.top) - SubnormBase;
    end else begin
      norm.mant = {1'b1, dec.frac};
      norm.shift = ShiftBits'(dec.exp_field) - ExpOffset;
    end
  end
endmodule

FILE: hdl/d2q_round.sv
// ----------------------------------------------------------------------------
// d2q_round
// half-up rounding to 31 bits, sign and special values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module d2q_round (
  input  d2q_pkg::norm_t norm,
  output d2q_pkg::res_t  res
);
  import d2q_pkg::*;

  logic [32:0] sum;
  logic [30:0] mag;

  always_comb begin
    sum = {1'b0, norm.mant[52:21]} + 33'd1;
    res.shift = norm.shift;
    if (sum[32]) begin
      mag = 31'h4000_0000;
      res.shift = norm.shift + 12'd1;
    end else begin
      mag = sum[31:1];
    end
    case (norm.cls)
      ClsNorm: res.mult = norm.neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
      ClsInf: begin
        res.mult = norm.neg ? MultNegMax : MultPosMax;
        res.shift = '0;
      end
      default: begin
        res.mult = '0;
        res.shift = '0;
      end
    endcase
  end
endmodule

FILE: hdl/double_to_q31_multiplier_shift.sv
// output valid once an accepted item has passed the decode, normalize and round registers
// throughput: one item per cycle; stages advance when the output is free or taken
// three register stages: decode with leading-zero count, normalize shift, round
// rst clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// double_to_q31_multiplier_shift
// converts a double bit pattern to a q31 multiplier and a shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module double_to_q31_multiplier_shift (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] multiplier,
  output logic signed [11:0] shift_amount
);
  import d2q_pkg::*;

  dec_t  dec_c, dec_r;
  norm_t norm_c, norm_r;
  res_t  res_c, res_r;
  logic  v1, v2, v3;
  logic  adv1, adv2, adv3;

  d2q_decode    u_dec  (.value_bits(value_bits), .dec(dec_c));
  d2q_normalize u_norm (.dec(dec_r), .norm(norm_c));
  d2q_round     u_rnd  (.norm(norm_r), .res(res_c));

  assign adv3 = !v3 || out_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) dec_r <= dec_c;
    if (adv2) norm_r <= norm_c;
    if (adv3) res_r <= res_c;
  end

  assign out_valid = v3;
  assign multiplier = res_r.mult;
  assign shift_amount = res_r.shift;
endmodule

FILE: hdl/d2q_checker.sv
// ----------------------------------------------------------------------------
// d2q_checker
// port-level checks for the double to q31 converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_to_q31_multiplier_shift_defines.svh"
module d2q_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] multiplier,
  input logic [11:0] shift_amount
);
  `D2Q_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !out_valid, "out valid right after reset")
  `D2Q_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(multiplier), "stalled result changed")
  `D2Q_ASSERT(a_free_ready, !out_valid |-> in_ready, "input stalled with empty output")
  `D2Q_ASSERT(a_zero_shift, out_valid && multiplier == 32'd0 |-> shift_amount == 12'd0, "zero multiplier with shift")
endmodule

bind double_to_q31_multiplier_shift d2q_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .multiplier(multiplier), .shift_amount(shift_amount)
);
